// ===== src/int8_vector_mac_unit_macros.svh =====
// ----------------------------------------------------------------------------
// int8 vector mac unit assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef INT8_VECTOR_MAC_UNIT_MACROS_SVH
`define INT8_VECTOR_MAC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define VMAC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// checked at every edge, reset included
`define VMAC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define VMAC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define VMAC_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ===== src/vmac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmac_pkg
// opcodes, limits and the instruction control struct of the vector mac unit
// ----------------------------------------------------------------------------
package vmac_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_BIAS = 2'd1;
    localparam logic [1:0] OP_MAC  = 2'd2;
    localparam logic [1:0] OP_ACT  = 2'd3;

    // bytes per 32-bit lane
    localparam logic [3:0] LANE_BYTES = 4'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] count;
        logic [4:0] shift;
    } ctrl_t;

endpackage

// ===== src/vmac_rf_bank.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmac_rf_bank
// one copy of the vector register file: one write port, one registered read
// port, per-entry written flags so unwritten entries read as zero
// ----------------------------------------------------------------------------
module vmac_rf_bank #(
    parameter int NUM_VREGS = 32,
    parameter int WIDTH     = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_VREGS)-1:0] wr_addr,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_VREGS)-1:0] rd_addr,
    output logic [WIDTH-1:0]             rd_data
);

    logic [WIDTH-1:0]     mem_reg [NUM_VREGS];
    logic [NUM_VREGS-1:0] written_reg;
    logic [WIDTH-1:0]     rd_mem_reg;
    logic                 rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_mem_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_mem_reg : '0;

endmodule

// ===== src/vmac_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmac_exec
// execute datapath: load, bias, int8 dot-product accumulate and
// relu/shift activation on the operands read for one instruction
// ----------------------------------------------------------------------------
module vmac_exec #(
    parameter int VREG_BYTES = 8,
    parameter int LANES      = 2
) (
    input  vmac_pkg::ctrl_t          ctrl,
    input  logic [63:0]              load_data,
    input  logic [31:0]              bias_value,
    input  logic [8*VREG_BYTES-1:0]  dst_val,
    input  logic [8*VREG_BYTES-1:0]  wgt_val,
    input  logic [8*VREG_BYTES-1:0]  act_val,
    output logic                     wr_en,
    output logic [8*VREG_BYTES-1:0]  wr_data,
    output logic [15:0]              act_bytes,
    output logic [1:0]               act_count
);

    localparam logic [3:0] VB_CNT = 4'(VREG_BYTES);
    localparam logic [3:0] LN_CNT = 4'(LANES);

    logic [3:0] load_n;
    logic [1:0] lane_n;
    logic [2:0] mac_n;

    logic [31:0]        dst_lane [LANES];
    logic [31:0]        wgt_lane [LANES];
    logic [31:0]        mac_lane [LANES];
    logic signed [16:0] prod     [LANES][4];
    logic signed [18:0] dot      [LANES];

    assign load_n = (ctrl.count > VB_CNT) ? VB_CNT : ctrl.count;
    assign lane_n = (ctrl.count > LN_CNT) ? LN_CNT[1:0] : ctrl.count[1:0];
    assign mac_n  = (ctrl.count > vmac_pkg::LANE_BYTES) ? vmac_pkg::LANE_BYTES[2:0]
                                                        : ctrl.count[2:0];

    // lane views and per-lane dot products
    for (genvar gl = 0; gl < LANES; gl++)
    begin : g_lane
        for (genvar gb = 0; gb < 4; gb++)
        begin : g_byte
            localparam int K = 4 * gl + gb;
            if (K < VREG_BYTES)
            begin : g_in
                assign dst_lane[gl][8*gb +: 8] = dst_val[8*K +: 8];
                assign wgt_lane[gl][8*gb +: 8] = wgt_val[8*K +: 8];
                assign prod[gl][gb] = (3'(gb) < mac_n)
                    ? 17'($signed(wgt_val[8*K +: 8])) * 17'($signed({1'b0, act_val[8*K +: 8]}))
                    : '0;
            end
            else
            begin : g_out
                assign dst_lane[gl][8*gb +: 8] = 8'd0;
                assign wgt_lane[gl][8*gb +: 8] = 8'd0;
                assign prod[gl][gb]            = '0;
            end
        end

        assign dot[gl] = 19'(prod[gl][0]) + 19'(prod[gl][1])
                       + 19'(prod[gl][2]) + 19'(prod[gl][3]);
        assign mac_lane[gl] = dst_lane[gl] + 32'(dot[gl]);
    end

    // result bytes written back
    for (genvar gk = 0; gk < VREG_BYTES; gk++)
    begin : g_wbyte
        localparam int L = gk / 4;
        localparam int B = gk % 4;
        logic [7:0] ld_b;
        logic [7:0] bias_b;
        logic [7:0] mac_b;

        assign ld_b = (4'(gk) < load_n) ? load_data[8*gk +: 8] : 8'd0;

        if (L < LANES)
        begin : g_lane_ok
            assign bias_b = (2'(L) < lane_n) ? bias_value[8*B +: 8] : 8'd0;
            assign mac_b  = mac_lane[L][8*B +: 8];
        end
        else
        begin : g_lane_none
            assign bias_b = 8'd0;
            assign mac_b  = dst_val[8*gk +: 8];
        end

        always_comb
        begin
            case (ctrl.op)
                vmac_pkg::OP_LOAD: wr_data[8*gk +: 8] = ld_b;
                vmac_pkg::OP_BIAS: wr_data[8*gk +: 8] = bias_b;
                vmac_pkg::OP_MAC:  wr_data[8*gk +: 8] = mac_b;
                default:           wr_data[8*gk +: 8] = dst_val[8*gk +: 8];
            endcase
        end
    end

    assign wr_en = (ctrl.op != vmac_pkg::OP_ACT);

    // relu then arithmetic shift, low byte per active lane
    for (genvar go = 0; go < 2; go++)
    begin : g_act
        if (go < LANES)
        begin : g_on
            logic [31:0] relu;
            assign relu = wgt_lane[go][31] ? 32'd0 : (wgt_lane[go] >> ctrl.shift);
            assign act_bytes[8*go +: 8] = (2'(go) < lane_n) ? relu[7:0] : 8'd0;
        end
        else
        begin : g_off
            assign act_bytes[8*go +: 8] = 8'd0;
        end
    end

    assign act_count = lane_n;

endmodule

// ===== src/int8_vector_mac_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_vector_mac_unit
// int8 vector unit: register file of vector registers with load, bias,
// signed-by-unsigned byte multiply-accumulate and relu/shift activation
// ----------------------------------------------------------------------------
// pipeline: two register stages, the input stage and the output reg that drives m_tvalid
// throughput: one instruction per cycle unless stalled; a write back that lands on the
//   same edge as the next beat's register file read is bridged by a one-entry bypass
// stalls only while an activate in the input stage waits on a full output reg
// reset: asynchronous, clears pipeline valids and per-entry written flags, so
//   every register reads zero at once; no clearing pass
`include "int8_vector_mac_unit_macros.svh"

module int8_vector_mac_unit #(
    parameter int NUM_VREGS  = 32,
    parameter int VREG_BYTES = 8,
    parameter int LANES      = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dest_reg, src_weight_reg, src_act_reg, count, load_data, bias_value, shift
    input  logic [119:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // act_bytes, act_count, zero pad
    output logic [23:0]  m_tdata
);

    localparam int IDX_W = $clog2(NUM_VREGS);
    localparam int RW    = 8 * VREG_BYTES;

    logic [IDX_W-1:0] idx_map [32];

    logic [IDX_W-1:0] in_dst_idx;
    logic [IDX_W-1:0] in_wgt_idx;
    logic [IDX_W-1:0] in_act_idx;

    logic             st_vld_reg;
    vmac_pkg::ctrl_t  st_ctrl_reg;
    logic [IDX_W-1:0] st_dst_idx_reg;
    logic [IDX_W-1:0] st_wgt_idx_reg;
    logic [IDX_W-1:0] st_act_idx_reg;
    logic [63:0]      st_load_reg;
    logic [31:0]      st_bias_reg;

    logic             byp_vld_reg;
    logic [IDX_W-1:0] byp_idx_reg;
    logic [RW-1:0]    byp_data_reg;

    logic             m_vld_reg;
    logic [17:0]      m_data_reg;

    logic [RW-1:0]    rf_dst;
    logic [RW-1:0]    rf_wgt;
    logic [RW-1:0]    rf_act;
    logic [RW-1:0]    dst_val;
    logic [RW-1:0]    wgt_val;
    logic [RW-1:0]    act_val;

    logic             ex_wr_en;
    logic [RW-1:0]    ex_wr_data;
    logic [15:0]      ex_act_bytes;
    logic [1:0]       ex_act_count;

    logic             is_act;
    logic             adv;
    logic             acc;
    logic             rf_we;

    // register number modulo file depth
    for (genvar gi = 0; gi < 32; gi++)
    begin : g_idx
        localparam int M = gi % NUM_VREGS;
        assign idx_map[gi] = IDX_W'(M);
    end

    assign in_dst_idx = idx_map[s_tdata[4:0]];
    assign in_wgt_idx = idx_map[s_tdata[9:5]];
    assign in_act_idx = idx_map[s_tdata[14:10]];

    assign is_act   = (st_ctrl_reg.op == vmac_pkg::OP_ACT);
    assign adv      = st_vld_reg && (!is_act || !m_vld_reg || m_tready);
    assign s_tready = !st_vld_reg || adv;
    assign acc      = s_tvalid && s_tready;
    assign rf_we    = adv && ex_wr_en;

    vmac_rf_bank #(.NUM_VREGS(NUM_VREGS), .WIDTH(RW)) u_bank_dst (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rf_we),
        .wr_addr (st_dst_idx_reg),
        .wr_data (ex_wr_data),
        .rd_en   (acc),
        .rd_addr (in_dst_idx),
        .rd_data (rf_dst)
    );

    vmac_rf_bank #(.NUM_VREGS(NUM_VREGS), .WIDTH(RW)) u_bank_wgt (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rf_we),
        .wr_addr (st_dst_idx_reg),
        .wr_data (ex_wr_data),
        .rd_en   (acc),
        .rd_addr (in_wgt_idx),
        .rd_data (rf_wgt)
    );

    vmac_rf_bank #(.NUM_VREGS(NUM_VREGS), .WIDTH(RW)) u_bank_act (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rf_we),
        .wr_addr (st_dst_idx_reg),
        .wr_data (ex_wr_data),
        .rd_en   (acc),
        .rd_addr (in_act_idx),
        .rd_data (rf_act)
    );

    // write that landed on the same edge as this beat's read
    assign dst_val = (byp_vld_reg && byp_idx_reg == st_dst_idx_reg) ? byp_data_reg : rf_dst;
    assign wgt_val = (byp_vld_reg && byp_idx_reg == st_wgt_idx_reg) ? byp_data_reg : rf_wgt;
    assign act_val = (byp_vld_reg && byp_idx_reg == st_act_idx_reg) ? byp_data_reg : rf_act;

    vmac_exec #(.VREG_BYTES(VREG_BYTES), .LANES(LANES)) u_exec (
        .ctrl       (st_ctrl_reg),
        .load_data  (st_load_reg),
        .bias_value (st_bias_reg),
        .dst_val    (dst_val),
        .wgt_val    (wgt_val),
        .act_val    (act_val),
        .wr_en      (ex_wr_en),
        .wr_data    (ex_wr_data),
        .act_bytes  (ex_act_bytes),
        .act_count  (ex_act_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg  <= 1'b0;
            byp_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                st_vld_reg  <= 1'b1;
                byp_vld_reg <= rf_we;
            end
            else if (adv)
            begin
                st_vld_reg <= 1'b0;
            end

            if (adv && is_act)
            begin
                m_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            st_ctrl_reg.op    <= s_tuser;
            st_ctrl_reg.count <= s_tdata[18:15];
            st_ctrl_reg.shift <= s_tdata[119:115];
            st_dst_idx_reg    <= in_dst_idx;
            st_wgt_idx_reg    <= in_wgt_idx;
            st_act_idx_reg    <= in_act_idx;
            st_load_reg       <= s_tdata[82:19];
            st_bias_reg       <= s_tdata[114:83];
            byp_idx_reg       <= st_dst_idx_reg;
            byp_data_reg      <= ex_wr_data;
        end
        if (adv && is_act)
        begin
            m_data_reg <= {ex_act_count, ex_act_bytes};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    `VMAC_ASSERT(a_empty_stage_ready, clk, rst_n, !st_vld_reg |-> s_tready, "idle stage not ready")
    `VMAC_ASSERT(a_write_never_stalls, clk, rst_n, (st_vld_reg && !is_act) |-> s_tready, "write op stalled")
    `VMAC_ASSERT(a_count_in_range, clk, rst_n, m_tvalid |-> (m_tdata[17:16] <= 2'(LANES)), "act_count above lanes")
    `VMAC_ASSERT(a_zero_count_zero_bytes, clk, rst_n, (m_tvalid && m_tdata[17:16] == 2'd0) |-> (m_tdata[15:0] == 16'd0), "bytes without lanes")
    `VMAC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> (!m_tvalid && !st_vld_reg), "busy in reset")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for int8_vector_mac_unit
// drives load, bias, multiply-accumulate and activate instructions on the
// input stream, keeps a copy of the vector register file and predicts every
// activate beat, then compares the output stream against it or the table's beat;
// a short table of directed instructions comes first, random ones follow,
// under changing amounts of idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  dest;
        logic [4:0]  wsrc;
        logic [4:0]  asrc;
        logic [3:0]  count;
        logic [63:0] data;
        logic [31:0] bias;
        logic [4:0]  shift;
    } vmac_instr_t;

    typedef struct {
        logic [15:0] bytes;
        logic [1:0]  lanes;
    } act_beat_t;

    typedef struct {
        vmac_instr_t instr;
        bit          typed;
        act_beat_t   beat;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;

    logic [63:0]  vreg_model [32];
    act_beat_t    act_beat_q [$];
    stim_row_t    stim_rows [$];
    int           mismatch_count = 0;
    int           sent_count = 0;
    int           send_idle_pct = 14;
    int           recv_idle_pct = 60;
    bit           hold_done = 1'b0;

    int8_vector_mac_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #5ms;
        $display("int8_vector_mac_unit test failed");
        $finish;
    end

    // executes one instruction on the register file copy
    function automatic void run_instr(input vmac_instr_t it, output bit emits,
                                      output act_beat_t beat);
        logic [63:0] wv;
        logic [63:0] av;
        logic [63:0] dv;
        logic [31:0] acc;
        logic [31:0] lane;
        logic [31:0] r;
        int          n;
        int          w;
        int          a;
        int          k;
        wv = vreg_model[it.wsrc];
        av = vreg_model[it.asrc];
        dv = vreg_model[it.dest];
        emits = 1'b0;
        beat.bytes = '0;
        beat.lanes = '0;
        case (it.op)
            vmac_pkg::OP_LOAD:
            begin
                n = (it.count > 8) ? 8 : int'(it.count);
                dv = '0;
                for (int i = 0; i < n; i++)
                    dv[8*i +: 8] = it.data[8*i +: 8];
                vreg_model[it.dest] = dv;
            end
            vmac_pkg::OP_BIAS:
            begin
                n = (it.count > 2) ? 2 : int'(it.count);
                dv = '0;
                for (int i = 0; i < n; i++)
                    dv[32*i +: 32] = it.bias;
                vreg_model[it.dest] = dv;
            end
            vmac_pkg::OP_MAC:
            begin
                n = (it.count > 4) ? 4 : int'(it.count);
                for (int i = 0; i < 2; i++)
                begin
                    acc = dv[32*i +: 32];
                    for (int j = 0; j < n; j++)
                    begin
                        k = 4*i + j;
                        w = $signed(wv[8*k +: 8]);
                        a = av[8*k +: 8];
                        acc = acc + 32'(w * a);
                    end
                    dv[32*i +: 32] = acc;
                end
                vreg_model[it.dest] = dv;
            end
            default:
            begin
                n = (it.count > 2) ? 2 : int'(it.count);
                for (int i = 0; i < n; i++)
                begin
                    lane = wv[32*i +: 32];
                    r = (lane != 0 && !lane[31]) ? (lane >> it.shift) : 32'd0;
                    beat.bytes[8*i +: 8] = r[7:0];
                end
                beat.lanes = 2'(n);
                emits = 1'b1;
            end
        endcase
    endfunction

    task automatic send_instr(input vmac_instr_t it, input bit typed,
                              input act_beat_t typed_beat);
        bit        emits;
        act_beat_t beat;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.shift, it.bias, it.data, it.count, it.asrc, it.wsrc, it.dest};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        run_instr(it, emits, beat);
        if (emits)
            act_beat_q.push_back(typed ? typed_beat : beat);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic vmac_instr_t random_instr();
        vmac_instr_t it;
        int          sel;
        sel = $urandom_range(99);
        it.op = (sel < 25) ? vmac_pkg::OP_LOAD
              : (sel < 40) ? vmac_pkg::OP_BIAS
              : (sel < 75) ? vmac_pkg::OP_MAC
              : vmac_pkg::OP_ACT;
        it.dest  = ($urandom_range(3) != 0) ? 5'($urandom_range(7)) : 5'($urandom);
        it.wsrc  = ($urandom_range(3) != 0) ? 5'($urandom_range(7)) : 5'($urandom);
        it.asrc  = ($urandom_range(3) != 0) ? 5'($urandom_range(7)) : 5'($urandom);
        it.count = ($urandom_range(4) != 0) ? 4'($urandom_range(8)) : 4'($urandom);
        case ($urandom_range(9))
            0:       it.data = '1;
            1:       it.data = 64'h8080_8080_8080_8080;
            default: it.data = {$urandom, $urandom};
        endcase
        case ($urandom_range(5))
            0:       it.bias = 32'h7fff_ffff;
            1:       it.bias = 32'h8000_0000;
            2, 3:    it.bias = 32'($urandom_range(65535));
            default: it.bias = $urandom;
        endcase
        it.shift = ($urandom_range(1) != 0) ? 5'($urandom_range(12)) : 5'($urandom);
        return it;
    endfunction

    function automatic stim_row_t stim_row(input logic [1:0] op, input int dest,
                                           input int wsrc, input int asrc,
                                           input int count, input logic [63:0] data,
                                           input logic [31:0] bias, input int shift,
                                           input bit typed, input logic [15:0] bytes,
                                           input logic [1:0] lanes);
        stim_row_t row;
        row.instr.op    = op;
        row.instr.dest  = 5'(dest);
        row.instr.wsrc  = 5'(wsrc);
        row.instr.asrc  = 5'(asrc);
        row.instr.count = 4'(count);
        row.instr.data  = data;
        row.instr.bias  = bias;
        row.instr.shift = 5'(shift);
        row.typed       = typed;
        row.beat.bytes  = bytes;
        row.beat.lanes  = lanes;
        return row;
    endfunction

    // output checker
    always @(posedge clk)
    begin
        act_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (act_beat_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: act_bytes %h act_count %0d",
                             m_tdata[15:0], m_tdata[17:16]);
            end
            else
            begin
                want = act_beat_q.pop_front();
                if (m_tdata[15:0] !== want.bytes || m_tdata[17:16] !== want.lanes)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: act_bytes %h/%h act_count %0d/%0d (exp/act)",
                                 want.bytes, m_tdata[15:0], want.lanes, m_tdata[17:16]);
                end
            end
        end
    end

    // output back-pressure, with one long hold early on
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_count >= 40)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        act_beat_t none;
        none.bytes = '0;
        none.lanes = '0;
        for (int r = 0; r < 32; r++)
            vreg_model[r] = '0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = vmac_pkg::OP_LOAD;

        // after reset, saturation, zero count, sign and shift extremes
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 9, 0, 2, 0, 0, 0, 1, 16'h0000, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_BIAS, 2, 0, 0, 2, 0,
                                     32'h7fff_ffff, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 2, 0, 2, 0, 0, 0, 1, 16'hffff, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 2, 0, 2, 0, 0, 31, 1, 16'h0000, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 2, 0, 15, 0, 0, 24, 1, 16'h7f7f, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 2, 0, 0, 0, 0, 0, 1, 16'h0000, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 2, 0, 1, 0, 0, 0, 1, 16'h00ff, 1));
        stim_rows.push_back(stim_row(vmac_pkg::OP_BIAS, 3, 0, 0, 15, 0,
                                     32'h8000_0000, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 3, 0, 2, 0, 0, 0, 1, 16'h0000, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_BIAS, 4, 0, 0, 1, 0,
                                     32'h1234_5678, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 4, 0, 2, 0, 0, 4, 1, 16'h0067, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_LOAD, 31, 0, 0, 8, '1, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_LOAD, 6, 0, 0, 15, '1, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_MAC, 7, 31, 6, 4, 0, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 7, 0, 2, 0, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_LOAD, 5, 0, 0, 8, 64'h7f80_017f_807f_80ff,
                                     0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_LOAD, 6, 0, 0, 5, 64'hffee_ddcc_bbaa_9988,
                                     0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_MAC, 4, 5, 6, 15, 0, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_MAC, 4, 5, 6, 0, 0, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_MAC, 5, 5, 5, 2, 0, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 4, 0, 2, 0, 0, 2, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 5, 0, 2, 0, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_LOAD, 2, 0, 0, 0, '1, 0, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_BIAS, 3, 0, 0, 0, 0,
                                     32'h7fff_ffff, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 2, 0, 2, 0, 0, 0, 1, 16'h0000, 2));
        stim_rows.push_back(stim_row(vmac_pkg::OP_ACT, 0, 3, 0, 2, 0, 0, 0, 1, 16'h0000, 2));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
            send_instr(stim_rows[i].instr, stim_rows[i].typed, stim_rows[i].beat);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 14 : 0;
            repeat (300)
                send_instr(random_instr(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (act_beat_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && act_beat_q.size() == 0)
            $display("int8_vector_mac_unit test passed");
        else
            $display("int8_vector_mac_unit test failed");
        $finish;
    end

endmodule

// ===== int8_vector_mac_unit.f =====
+incdir+src
src/vmac_pkg.sv
src/vmac_rf_bank.sv
src/vmac_exec.sv
src/int8_vector_mac_unit.sv
tb/testbench.sv
